// File: design/sla_pkg.sv
package sla_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [6:0] MAX_EMIT = 7'd63;

endpackage

// File: design/sla_mem.sv
module sla_mem #(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(LINE_STORE_DEPTH)-1:0] waddr,
  input  logic [7:0]                          wdata,
  input  logic [$clog2(LINE_STORE_DEPTH)-1:0] raddr,
  output logic [7:0]                          rdata
);

  logic [7:0] store [LINE_STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

// File: design/sla_ctrl.sv
module sla_ctrl #(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          line_char,
  output logic [5:0]                          line_length,
  output logic                                last_char,
  output logic                                mem_we,
  output logic [$clog2(LINE_STORE_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                          mem_wdata,
  output logic [$clog2(LINE_STORE_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                          mem_rdata
);

  localparam int AW = $clog2(LINE_STORE_DEPTH);
  localparam int FW = $clog2(LINE_STORE_DEPTH + 1);

  sla_pkg::state_t state, state_next;
  logic [FW-1:0]   fill, fill_next;
  logic [5:0]      lim, lim_next;
  logic [5:0]      cnt, cnt_next;
  logic [5:0]      n, n_next;
  logic [6:0]      fill7;
  logic [5:0]      cnt_inc;
  logic            accept, has_room, is_term, out_load;

  assign in_stall  = (state != sla_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign has_room  = fill < FW'(LINE_STORE_DEPTH);
  assign is_term   = (rx_byte == sla_pkg::CH_CR) || (rx_byte == sla_pkg::CH_LF);
  assign fill7     = 7'(fill);
  assign cnt_inc   = cnt + 6'd1;
  assign mem_waddr = AW'(fill);
  assign mem_wdata = rx_byte;

  always_comb begin
    state_next = state;
    fill_next  = fill;
    lim_next   = lim;
    cnt_next   = cnt;
    n_next     = n;
    mem_we     = 1'b0;
    mem_raddr  = AW'(cnt);
    out_load   = 1'b0;
    unique case (state)
      sla_pkg::ST_IDLE: begin
        if (accept) begin
          mem_we = has_room;
          if (has_room) begin
            fill_next = fill + FW'(1);
          end
          if (is_term) begin
            fill_next = '0;
            if (has_room && (fill != '0)) begin
              lim_next   = (fill7 > sla_pkg::MAX_EMIT) ? 6'(sla_pkg::MAX_EMIT) : 6'(fill7);
              cnt_next   = '0;
              mem_raddr  = '0;
              state_next = sla_pkg::ST_SCAN;
            end
          end
        end
      end
      sla_pkg::ST_SCAN: begin
        if ((mem_rdata == 8'd0) || (cnt_inc == lim)) begin
          n_next     = (mem_rdata == 8'd0) ? cnt : lim;
          cnt_next   = '0;
          mem_raddr  = '0;
          state_next = (n_next == '0) ? sla_pkg::ST_IDLE : sla_pkg::ST_EMIT;
        end else begin
          cnt_next  = cnt_inc;
          mem_raddr = AW'(cnt_inc);
        end
      end
      sla_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          cnt_next  = cnt_inc;
          mem_raddr = AW'(cnt_inc);
          if (cnt_inc == n) begin
            state_next = sla_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sla_pkg::ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    lim <= lim_next;
    cnt <= cnt_next;
    n   <= n_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line_char   <= mem_rdata;
      line_length <= n;
      last_char   <= (cnt_inc == n);
    end
  end

endmodule

// File: design/serial_line_assembler.sv
// Serial line assembler.
// Input channel: rx_byte with in_valid / in_stall; one byte per transaction.
// Output channel: line_char, line_length, last_char with out_valid / out_stall;
// one character of a finished line per transaction, last_char on the final one.
// Ordinary bytes are stored into a line store with one write and one read
// port. On CR or LF the sequencer walks the store with one read per cycle,
// held during emission while the receiver stalls, through a shared counter
// and zero compare: a scan finds the line length n, then the n characters
// are emitted. in_stall is therefore high from the line end until the last
// character has been loaded into the output register, also while the
// receiver stalls. Overflowed, empty or zero-led lines produce none.
// A result waits in the output register while out_stall is high; emission
// pauses and the store read is held. A byte may be accepted while the last
// character of the previous line still waits to be taken.
// Reset clears the fill index, the sequencer and out_valid. The line store is
// not cleared; only entries written in the current line are read.
module serial_line_assembler #(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] line_char,
  output logic [5:0] line_length,
  output logic       last_char
);

  localparam int AW = $clog2(LINE_STORE_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  sla_ctrl #(
    .LINE_STORE_DEPTH(LINE_STORE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_char  (line_char),
    .line_length(line_length),
    .last_char  (last_char),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sla_mem #(
    .LINE_STORE_DEPTH(LINE_STORE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_length != 6'd0))
    else $error("result with zero line length");

  a_next_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_char) |=> out_valid)
    else $error("gap inside an emitted line");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_char) |-> in_stall)
    else $error("input taken while a line is being emitted");

  a_plain_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (rx_byte != sla_pkg::CH_CR) &&
     (rx_byte != sla_pkg::CH_LF)) |=> !in_stall)
    else $error("stall after an ordinary byte");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 100;
  localparam int TAIL_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [7:0] ch;
    logic [5:0] len;
    logic       last;
  } line_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] line_char;
  logic [5:0] line_length;
  logic       last_char;

  serial_line_assembler #(.LINE_STORE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .line_char(line_char),
    .line_length(line_length),
    .last_char(last_char)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // line predictor state
  logic [7:0]  line_buf [DEPTH];
  int unsigned fill_cnt = 0;
  line_char_t  pending_chars [$];

  int  mismatches = 0;
  int  accepted_cnt = 0;
  int  cycle_cnt = 0;
  int  stall_left = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == sla_pkg::CH_CR || b == sla_pkg::CH_LF);
    return b;
  endfunction

  task automatic assemble_byte(input logic [7:0] b);
    bit          kept;
    int unsigned body;
    int unsigned n;
    line_char_t  e;
    kept = 1'b0;
    if (fill_cnt < DEPTH) begin
      line_buf[fill_cnt] = b;
      fill_cnt++;
      kept = 1'b1;
    end
    if (b == sla_pkg::CH_CR || b == sla_pkg::CH_LF) begin
      body = fill_cnt;
      fill_cnt = 0;
      if (kept && body != 0) begin
        body--;
        n = 0;
        while (n < body && n < sla_pkg::MAX_EMIT && line_buf[n] != 8'd0) n++;
        for (int unsigned k = 0; k < n; k++) begin
          e.ch   = line_buf[k];
          e.len  = 6'(n);
          e.last = (k + 1 == n);
          pending_chars.push_back(e);
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    assemble_byte(b);
    accepted_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  task automatic check_result();
    line_char_t e;
    if (pending_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transaction: char=%02h len=%0d last=%0b",
                 line_char, line_length, last_char);
      return;
    end
    e = pending_chars.pop_front();
    if (line_char !== e.ch || line_length !== e.len || last_char !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp char=%02h len=%0d last=%0b, got char=%02h len=%0d last=%0b",
                 e.ch, e.len, e.last, line_char, line_length, last_char);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(rx_calm);
        if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_short_lines();
    send_byte(8'hFF); send_byte(8'h80); send_byte(8'h01); send_byte(sla_pkg::CH_LF);
    send_byte(8'hAA); send_byte(sla_pkg::CH_CR);
    send_byte(8'h55); send_byte(8'h7F); send_byte(sla_pkg::CH_CR);
    send_byte(sla_pkg::CH_LF);
    send_byte(8'h41); send_byte(sla_pkg::CH_CR); send_byte(sla_pkg::CH_LF);
  endtask

  task automatic test_zero_bytes();
    send_byte(8'h00); send_byte(8'h61); send_byte(sla_pkg::CH_CR);
    send_byte(8'h61); send_byte(8'h62); send_byte(8'h00); send_byte(8'h63);
    send_byte(sla_pkg::CH_LF);
    send_byte(8'h00); send_byte(sla_pkg::CH_LF);
  endtask

  task automatic test_terminator_fits();
    for (int i = 0; i < DEPTH - 1; i++) send_byte(rand_text_byte());
    send_byte(sla_pkg::CH_CR);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < DEPTH; i++) send_byte(rand_text_byte());
    send_byte(8'h5A);
    send_byte(sla_pkg::CH_LF);
    for (int i = 0; i < DEPTH; i++) send_byte(rand_text_byte());
    send_byte(sla_pkg::CH_CR);
    send_byte(8'h6F); send_byte(8'h6B); send_byte(sla_pkg::CH_CR);
  endtask

  task automatic test_drain_pause();
    send_byte(8'h31); send_byte(8'h32); send_byte(8'h33); send_byte(sla_pkg::CH_LF);
    wait_drained();
    send_byte(8'h34); send_byte(sla_pkg::CH_CR);
  endtask

  task automatic send_random_line();
    int r;
    int len;
    r = $urandom_range(0, 99);
    tx_calm = ($urandom_range(0, 5) == 0);
    if (r < 10) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 20) len = 0;
    else if (r < 85) len = $urandom_range(1, 10);
    else if (r < 97) len = $urandom_range(11, 62);
    else len = $urandom_range(63, 70);
    for (int i = 0; i < len; i++)
      send_byte(($urandom_range(0, 19) == 0) ? 8'h00 : rand_text_byte());
    send_byte($urandom_range(0, 1) ? sla_pkg::CH_CR : sla_pkg::CH_LF);
  endtask

  task automatic test_random_lines();
    int start_cnt;
    start_cnt = accepted_cnt;
    while (accepted_cnt - start_cnt < RANDOM_ITEMS) send_random_line();
    tx_calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_short_lines();
    test_zero_bytes();
    test_terminator_fits();
    test_store_full();
    test_drain_pause();
    test_random_lines();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      mismatches++;
      $display("%0d expected transactions never arrived", pending_chars.size());
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
